// File: rtl/wcdd_pkg.sv
package wcdd_pkg;

    // Fraction bits of the Q8.24 gain registers.
    localparam int unsigned GAIN_FRAC_BITS = 24;
    localparam logic [31:0] GAIN_RESET     = 32'h0100_0000;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_X_GAIN = 1'b0,
        CFG_Y_GAIN = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic               is_origin;
        logic               double_delta;
        logic signed [31:0] lat_value;
        logic signed [31:0] lon_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
    } t_out;

endpackage

// File: rtl/wcdd_proj.sv
module wcdd_proj (
    input  logic               i_clk,
    input  logic signed [31:0] i_pos,
    input  logic        [31:0] i_gain,
    input  logic               i_negate,
    output logic signed [31:0] o_coord
);
    import wcdd_pkg::*;

    localparam logic [39:0] LIM_POS = 40'h00_7FFF_FFFF;
    localparam logic [39:0] LIM_NEG = 40'h00_8000_0000;

    logic [31:0] mag;
    logic [63:0] n_prod;
    logic [63:0] r_prod;
    logic        n_neg;
    logic        r_neg;
    logic [39:0] quo;

    // Magnitude of the position; the most negative value maps to 2^31.
    assign mag    = i_pos[31] ? (~i_pos + 32'd1) : i_pos;
    assign n_prod = 64'(mag) * 64'(i_gain);
    assign n_neg  = i_pos[31] ^ i_negate;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_neg  <= n_neg;
    end

    // Dropping the fraction of the magnitude truncates toward zero.
    assign quo = r_prod[63:GAIN_FRAC_BITS];

    always_comb begin
        if (r_neg) begin
            if (quo > LIM_NEG) begin
                o_coord = 32'sh8000_0000;
            end else begin
                o_coord = ~quo[31:0] + 32'd1;
            end
        end else begin
            if (quo > LIM_POS) begin
                o_coord = 32'sh7FFF_FFFF;
            end else begin
                o_coord = quo[31:0];
            end
        end
    end

endmodule

// File: rtl/way_coord_delta_decoder_unit.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_stall         i_data (wcdd_pkg::t_in)
// output    out        o_valid / i_stall         o_data (wcdd_pkg::t_out)
// config    in         i_cfg_we                  i_cfg_addr, i_cfg_data
//
// One transaction per cycle is accepted while o_stall is low. The accepting edge updates
// the position, the product is then registered in wcdd_proj, and the saturated result is
// then written into the queue, which raises o_valid so that the result can leave.
// The rate is set by the position recurrence and the registered multiplier.
// Reset (synchronous, active low) clears positions, deltas and queue; gains go to 1.0.
// o_stall is a register: it rises when every slot of the output queue is claimed
// by queued results or results still in the pipeline.
module way_coord_delta_decoder_unit #(
    parameter int unsigned OUT_DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  wcdd_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output wcdd_pkg::t_out o_data,
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_addr,
    input  logic [31:0]    i_cfg_data
);
    import wcdd_pkg::*;

    localparam int unsigned PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int unsigned CW = $clog2(OUT_DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(OUT_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(OUT_DEPTH - 1);

    logic accept;
    logic pop;

    // Gain registers.
    logic [31:0] r_x_gain;
    logic [31:0] r_y_gain;

    // Decoder state. The position registers also serve as the first stage.
    logic signed [31:0] r_lat_pos;
    logic signed [31:0] r_lon_pos;
    logic signed [31:0] r_lat_prev;
    logic signed [31:0] r_lon_prev;
    logic signed [31:0] n_lat_prev;
    logic signed [31:0] n_lon_prev;

    // Pipeline valid bits.
    logic r_v1;
    logic r_v2;

    // Output queue and its occupancy bookkeeping.
    t_out          r_fifo [OUT_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_fifo_cnt;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_stall;
    t_out          proj_res;

    assign accept  = i_valid && !r_stall;
    assign o_stall = r_stall;
    assign o_valid = (r_fifo_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_fifo[r_rd_ptr];

    // Configuration writes must arrive only while the block is idle; not enforced here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_gain <= GAIN_RESET;
            r_y_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_X_GAIN: r_x_gain <= i_cfg_data;
                CFG_Y_GAIN: r_y_gain <= i_cfg_data;
                default:    r_x_gain <= r_x_gain;
            endcase
        end
    end

    // A double delta first accumulates into the previous delta, which is then
    // added to the position. All sums wrap modulo 2^32.
    assign n_lat_prev = r_lat_prev + i_data.lat_value;
    assign n_lon_prev = r_lon_prev + i_data.lon_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_pos  <= '0;
            r_lon_pos  <= '0;
            r_lat_prev <= '0;
            r_lon_prev <= '0;
        end else if (accept) begin
            if (i_data.is_origin) begin
                r_lat_pos  <= i_data.lat_value;
                r_lon_pos  <= i_data.lon_value;
                r_lat_prev <= '0;
                r_lon_prev <= '0;
            end else if (i_data.double_delta) begin
                r_lat_prev <= n_lat_prev;
                r_lon_prev <= n_lon_prev;
                r_lat_pos  <= r_lat_pos + n_lat_prev;
                r_lon_pos  <= r_lon_pos + n_lon_prev;
            end else begin
                r_lat_pos <= r_lat_pos + i_data.lat_value;
                r_lon_pos <= r_lon_pos + i_data.lon_value;
            end
        end
    end

    // Projection: the product is registered inside wcdd_proj, then truncated and
    // saturated on its way into the output queue.
    wcdd_proj u_proj_x (
        .i_clk    (i_clk),
        .i_pos    (r_lon_pos),
        .i_gain   (r_x_gain),
        .i_negate (1'b0),
        .o_coord  (proj_res.x_coord)
    );

    wcdd_proj u_proj_y (
        .i_clk    (i_clk),
        .i_pos    (r_lat_pos),
        .i_gain   (r_y_gain),
        .i_negate (1'b1),
        .o_coord  (proj_res.y_coord)
    );

    // The total count covers queued results and those still in the pipeline,
    // so a registered stall is enough to keep the queue from overflowing.
    always_comb begin
        n_cnt = r_cnt;
        if (accept && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!accept && pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_cnt      <= '0;
            r_stall    <= 1'b0;
            r_fifo_cnt <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
        end else begin
            r_v1    <= accept;
            r_v2    <= r_v1;
            r_cnt   <= n_cnt;
            r_stall <= (n_cnt == CNT_FULL);
            if (r_v2 && !pop) begin
                r_fifo_cnt <= r_fifo_cnt + CW'(1);
            end else if (!r_v2 && pop) begin
                r_fifo_cnt <= r_fifo_cnt - CW'(1);
            end
            if (r_v2) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_fifo[r_wr_ptr] <= proj_res;
        end
    end

    // A result leaving the pipeline always finds a free queue slot.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_fifo_cnt != CNT_FULL) || pop)
        else $error("output queue overflow");

    // The total count matches the pipeline and queue contents.
    a_cnt_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == (CW'(r_v1) + CW'(r_v2) + r_fifo_cnt))
        else $error("occupancy count out of step");

    // An origin transaction clears the previous deltas.
    a_origin_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_data.is_origin |=> (r_lat_prev == '0) && (r_lon_prev == '0))
        else $error("origin did not clear deltas");

    // A single delta leaves the previous deltas unchanged.
    a_single_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_data.is_origin && !i_data.double_delta
        |=> $stable(r_lat_prev) && $stable(r_lon_prev))
        else $error("single delta changed previous deltas");

endmodule

// File: tb/way_coord_delta_decoder_unit_test.sv
`timescale 1ns / 100ps

module way_coord_delta_decoder_unit_test;

    import wcdd_pkg::*;

    // Cycles in which neither channel completes a transaction before the run is declared hung.
    // The longest legitimate quiet stretch comes from the receiver hold-off.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Length of the receiver hold-off that forces the block to back up and stall its input.
    localparam int unsigned HOLD_CYCLES    = 300;
    // Time for results still in the pipeline to leave, with a little margin on top.
    localparam int unsigned SETTLE_CYCLES  = 6;
    // Mismatch reports are capped so that a badly broken block does not flood the log.
    localparam int unsigned REPORT_CAP     = 150;
    localparam int unsigned NUM_PHASES     = 8;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    t_in         i_data     = '0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    t_out        o_data;
    logic        i_cfg_we   = 1'b0;
    logic [0:0]  i_cfg_addr = CFG_X_GAIN;
    logic [31:0] i_cfg_data = '0;

    way_coord_delta_decoder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    // Free-running 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Nodes waiting to be offered, and projected points waiting to come out.
    t_in  node_queue[$];
    t_out pending_points[$];

    // Shadow of the decoder: gains as written, plus the running position and the
    // previous delta used by double-delta encoding.
    logic [31:0]        trk_x_gain = GAIN_RESET;
    logic [31:0]        trk_y_gain = GAIN_RESET;
    logic signed [31:0] trk_lat_pos;
    logic signed [31:0] trk_lon_pos;
    logic signed [31:0] trk_lat_step;
    logic signed [31:0] trk_lon_step;

    // Handshake results of the most recent rising edge, read by the driver at the next
    // falling edge.
    bit node_taken;
    bit point_taken;

    int unsigned idle_cycles;
    int unsigned fail_count;

    // Traffic shaping knobs, written only by the sequencing block between phases.
    int unsigned gap_max   = 0;
    int unsigned stall_pct = 0;
    bit          hold_arm  = 1'b0;

    // Sender burst state and receiver hold-off state, owned by their own processes.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;

    // Projects one coordinate: the signed position times the unsigned Q8.24 gain,
    // truncated toward zero, optionally negated, then clamped to 32 signed bits.
    function automatic logic signed [31:0] scale_coord(logic signed [31:0] pos,
                                                       logic [31:0] gain, bit negate);
        longint      s;
        logic [63:0] mag;
        logic [63:0] prod;
        longint      v;
        s    = longint'(pos);
        mag  = (s < 0) ? 64'(-s) : 64'(s);
        prod = (mag * {32'd0, gain}) >> GAIN_FRAC_BITS;
        v    = longint'(prod);
        if (s < 0)
            v = -v;
        if (negate)
            v = -v;
        if (v > SAT_HI)
            v = SAT_HI;
        if (v < SAT_LO)
            v = SAT_LO;
        return v[31:0];
    endfunction

    // Advances the shadow position by one node and returns the point it projects to.
    // All sums wrap at 32 bits, exactly like the hardware accumulators.
    function automatic t_out project_node(t_in node);
        t_out pt;
        if (node.is_origin) begin
            // An origin resets the double-delta history; double_delta is ignored here.
            trk_lat_pos  = node.lat_value;
            trk_lon_pos  = node.lon_value;
            trk_lat_step = '0;
            trk_lon_step = '0;
        end else if (node.double_delta) begin
            trk_lat_step = trk_lat_step + node.lat_value;
            trk_lon_step = trk_lon_step + node.lon_value;
            trk_lat_pos  = trk_lat_pos + trk_lat_step;
            trk_lon_pos  = trk_lon_pos + trk_lon_step;
        end else begin
            // A single delta leaves the double-delta history alone.
            trk_lat_pos = trk_lat_pos + node.lat_value;
            trk_lon_pos = trk_lon_pos + node.lon_value;
        end
        pt.x_coord = scale_coord(trk_lon_pos, trk_x_gain, 1'b0);
        pt.y_coord = scale_coord(trk_lat_pos, trk_y_gain, 1'b1);
        return pt;
    endfunction

    function automatic void check_point(t_out got);
        t_out want;
        if (pending_points.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $error("unexpected point x_coord=%0d y_coord=%0d", got.x_coord, got.y_coord);
            return;
        end
        want = pending_points.pop_front();
        if (got.x_coord !== want.x_coord) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $error("x_coord mismatch: expected %0d, actual %0d",
                       want.x_coord, got.x_coord);
        end
        if (got.y_coord !== want.y_coord) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $error("y_coord mismatch: expected %0d, actual %0d",
                       want.y_coord, got.y_coord);
        end
    endfunction

    // Rising edge: sample both handshakes, keep the shadow model in step with
    // configuration writes and accepted nodes, score results, and run the watchdog.
    always @(posedge i_clk) begin
        node_taken  = i_rst_n && i_valid && !o_stall;
        point_taken = i_rst_n && o_valid && !i_stall;
        if (!i_rst_n) begin
            trk_x_gain   = GAIN_RESET;
            trk_y_gain   = GAIN_RESET;
            trk_lat_pos  = '0;
            trk_lon_pos  = '0;
            trk_lat_step = '0;
            trk_lon_step = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_X_GAIN)
                    trk_x_gain = i_cfg_data;
                else
                    trk_y_gain = i_cfg_data;
            end
            if (node_taken)
                pending_points.push_back(project_node(i_data));
            if (point_taken)
                check_point(o_data);
        end

        if (!i_rst_n || node_taken || point_taken)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sender: offers queued nodes in bursts of random length separated by random gaps.
    // A new node is only put on the bus once the previous one has been accepted, so a
    // stalled payload never changes.
    always @(negedge i_clk) begin
        if (!i_valid || node_taken) begin
            if (gap_left > 0 || node_queue.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end else begin
                i_data  <= node_queue.pop_front();
                i_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Receiver: random stalls at a per-phase rate. Once armed, it also holds off for a
    // long stretch so the output queue fills and the block pushes back on its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_arm && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic t_in make_node(bit origin, bit dbl, logic [31:0] lat, logic [31:0] lon);
        t_in n;
        n.is_origin    = origin;
        n.double_delta = dbl;
        n.lat_value    = lat;
        n.lon_value    = lon;
        return n;
    endfunction

    // A word from anywhere in the 32-bit range, leaning on the corners.
    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            3: return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    // A coordinate step: small as in real polylines, now and then anything at all.
    function automatic logic [31:0] step_word(bit dbl);
        if ($urandom_range(0, 19) == 0)
            return any_word();
        if (dbl)
            return 32'($urandom_range(0, 1000)) - 32'd500;
        return 32'($urandom_range(0, 40000)) - 32'd20000;
    endfunction

    // Queues one polygon (origin plus deltas with random content), or, now and then,
    // a stray node that may break the sequence.
    task automatic queue_polygon(ref int unsigned queued);
        int unsigned n_steps;
        int unsigned style;
        bit          dbl;
        logic [31:0] lat;
        logic [31:0] lon;
        if ($urandom_range(0, 99) < 12) begin
            node_queue.push_back(make_node(1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1)),
                                           any_word(), any_word()));
            queued++;
            return;
        end
        if ($urandom_range(0, 4) == 0) begin
            lat = any_word();
            lon = any_word();
        end else begin
            lat = 32'($urandom_range(0, 180_000_000)) - 32'd90_000_000;
            lon = 32'($urandom_range(0, 360_000_000)) - 32'd180_000_000;
        end
        node_queue.push_back(make_node(1'b1, 1'($urandom_range(0, 1)), lat, lon));
        queued++;
        n_steps = $urandom_range(1, 20);
        style   = $urandom_range(0, 2);
        repeat (n_steps) begin
            dbl = (style == 2) ? 1'($urandom_range(0, 1)) : 1'(style);
            node_queue.push_back(make_node(1'b0, dbl, step_word(dbl), step_word(dbl)));
            queued++;
        end
    endtask

    // Waits until every node is in and every point is out, then lets the pipeline settle
    // before anything touches the gain registers.
    task automatic wait_drained();
        while (node_queue.size() != 0 || i_valid || pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both gains on consecutive cycles, with write enable held high throughout.
    task automatic write_gains(logic [31:0] gx, logic [31:0] gy);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_X_GAIN;
        i_cfg_data <= gx;
        @(negedge i_clk);
        i_cfg_addr <= CFG_Y_GAIN;
        i_cfg_data <= gy;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] map_gain();
        return 32'($urandom_range(32'h0004_0000, 32'h0400_0000));
    endfunction

    initial begin
        int unsigned queued;
        int unsigned n_nodes;
        logic [31:0] gx;
        logic [31:0] gy;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed nodes at the reset gains of 1.0. The first two arrive before any
        // origin and so build on the zero reset position and history.
        node_queue.push_back(make_node(1'b0, 1'b0, 32'd100, -32'sd200));
        node_queue.push_back(make_node(1'b0, 1'b1, 32'd3, 32'd4));
        // Origin with double_delta set, which must be ignored.
        node_queue.push_back(make_node(1'b1, 1'b1, 32'd90_000_000, -32'sd180_000_000));
        node_queue.push_back(make_node(1'b0, 1'b0, -32'sd5, 32'd7));
        node_queue.push_back(make_node(1'b0, 1'b1, 32'd10, -32'sd10));
        node_queue.push_back(make_node(1'b0, 1'b1, 32'd10, -32'sd10));
        // A single delta in the middle must not disturb the double-delta history.
        node_queue.push_back(make_node(1'b0, 1'b0, 32'd1, 32'd1));
        node_queue.push_back(make_node(1'b0, 1'b1, 32'd0, 32'd0));
        // Most negative latitude: its negation saturates y.
        node_queue.push_back(make_node(1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF));
        // Position sums wrap around in both directions.
        node_queue.push_back(make_node(1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0001));
        node_queue.push_back(make_node(1'b1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000));
        node_queue.push_back(make_node(1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000));
        node_queue.push_back(make_node(1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000));
        node_queue.push_back(make_node(1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        node_queue.push_back(make_node(1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF));
        wait_drained();

        // Random phases, each with its own gains and traffic shape. The gain list takes
        // in zero, the full-scale maximum, the smallest nonzero step, map-like values,
        // and finally the reset value written back explicitly.
        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            n_nodes = 150;
            case (ph)
                0: begin gx = 32'hFFFF_FFFF; gy = 32'h0000_0000;
                         stall_pct = 20; gap_max = 4; end
                1: begin gx = 32'h0000_0000; gy = 32'hFFFF_FFFF;
                         stall_pct = 50; gap_max = 0; end
                2: begin gx = 32'h0000_0001; gy = 32'h0000_0001;
                         stall_pct = 10; gap_max = 10; end
                3: begin gx = map_gain(); gy = map_gain();
                         stall_pct = 0;  gap_max = 0; n_nodes = 200; end
                4: begin gx = map_gain(); gy = map_gain();
                         stall_pct = 10; gap_max = 0; n_nodes = 200; end
                5: begin gx = $urandom; gy = $urandom;
                         stall_pct = 70; gap_max = 8; end
                6: begin gx = 32'hFFFF_FFFF; gy = 32'hFFFF_FFFF;
                         stall_pct = 30; gap_max = 2; end
                default: begin gx = GAIN_RESET; gy = GAIN_RESET;
                         stall_pct = 40; gap_max = 6; n_nodes = 200; end
            endcase
            write_gains(gx, gy);
            // In the back-pressure phase the sender keeps offering while the receiver
            // sits on its hands.
            if (ph == 4)
                hold_arm = 1'b1;
            queued = 0;
            while (queued < n_nodes) begin
                queue_polygon(queued);
                @(negedge i_clk);
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/wcdd_pkg.sv
rtl/wcdd_proj.sv
rtl/way_coord_delta_decoder_unit.sv
tb/way_coord_delta_decoder_unit_test.sv
